/* rtl/owbm_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// owbm_pkg - shared types and constants of the one-wire bus master
// Command codes, tick item and result layouts, register map and reset values.
// ----------------------------------------------------------------------------
package owbm_pkg;

    // Register file
    localparam int CFG_W          = 10;
    localparam int NUM_REGS       = 7;
    localparam int APB_DW         = 32;
    localparam int APB_AW         = 5;
    localparam int COUNT_WIDTH_DEF = 10;
    localparam int QUEUE_DEPTH    = 2;

    localparam logic [2:0] REG_RESET_LOW     = 3'd0;
    localparam logic [2:0] REG_PRESENCE_WAIT = 3'd1;
    localparam logic [2:0] REG_RESET_REC     = 3'd2;
    localparam logic [2:0] REG_SLOT_LOW      = 3'd3;
    localparam logic [2:0] REG_WRITE_HOLD    = 3'd4;
    localparam logic [2:0] REG_READ_SAMPLE   = 3'd5;
    localparam logic [2:0] REG_READ_REC      = 3'd6;

    localparam logic [CFG_W-1:0] RST_RESET_LOW     = 10'd500;
    localparam logic [CFG_W-1:0] RST_PRESENCE_WAIT = 10'd70;
    localparam logic [CFG_W-1:0] RST_RESET_REC     = 10'd500;
    localparam logic [CFG_W-1:0] RST_SLOT_LOW      = 10'd10;
    localparam logic [CFG_W-1:0] RST_WRITE_HOLD    = 10'd50;
    localparam logic [CFG_W-1:0] RST_READ_SAMPLE   = 10'd5;
    localparam logic [CFG_W-1:0] RST_READ_REC      = 10'd50;

    typedef enum logic [1:0] {
        CMD_NONE  = 2'd0,
        CMD_RESET = 2'd1,
        CMD_WRITE = 2'd2,
        CMD_READ  = 2'd3
    } cmd_t;

    // One tick as it travels from the front stage to the engine
    typedef struct packed {
        cmd_t       cmd;
        logic [7:0] write_data;
        logic       line_level;
    } item_t;

    // One tick's result
    typedef struct packed {
        logic [7:0] read_data;
        logic       presence_level;
        logic       done_res;
        logic       busy_res;
        logic       drive_low;
    } result_t;

    typedef struct packed {
        logic [CFG_W-1:0] reset_low_ticks;
        logic [CFG_W-1:0] presence_wait_ticks;
        logic [CFG_W-1:0] reset_recovery_ticks;
        logic [CFG_W-1:0] slot_low_ticks;
        logic [CFG_W-1:0] write_hold_ticks;
        logic [CFG_W-1:0] read_sample_ticks;
        logic [CFG_W-1:0] read_recovery_ticks;
    } cfg_t;

endpackage
`default_nettype wire

/* rtl/owbm_front.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// owbm_front - input stage
// Register each tick request and classify its opcode into a command code.
// ----------------------------------------------------------------------------
module owbm_front (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire logic [1:0]      in_opcode,
    input  wire logic [7:0]      in_write_data,
    input  wire logic            in_line_level,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output owbm_pkg::item_t      out_item
);

    logic            valid_reg;
    owbm_pkg::item_t item_reg;
    owbm_pkg::item_t item_next;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    always_comb begin
        unique case (in_opcode)
            owbm_pkg::CMD_RESET: item_next.cmd = owbm_pkg::CMD_RESET;
            owbm_pkg::CMD_WRITE: item_next.cmd = owbm_pkg::CMD_WRITE;
            owbm_pkg::CMD_READ:  item_next.cmd = owbm_pkg::CMD_READ;
            default:             item_next.cmd = owbm_pkg::CMD_NONE;
        endcase
        item_next.write_data = in_write_data;
        item_next.line_level = in_line_level;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
        if (in_ready && in_valid) begin
            item_reg <= item_next;
        end
    end

endmodule
`default_nettype wire

/* rtl/owbm_queue.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// owbm_queue - request queue
// Short FIFO between the input stage and the engine; push and pop may coincide.
// ----------------------------------------------------------------------------
module owbm_queue (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            push_valid,
    output logic                 push_ready,
    input  owbm_pkg::item_t      push_item,
    output logic                 pop_valid,
    input  wire logic            pop_ready,
    output owbm_pkg::item_t      pop_item
);

    localparam int DEPTH = owbm_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    owbm_pkg::item_t  mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push, do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = mem[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
        if (do_push) begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

endmodule
`default_nettype wire

/* rtl/owbm_engine.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// owbm_engine - bus timing engine
// Advance the reset, write and read sequences one tick per request.
// ----------------------------------------------------------------------------
module owbm_engine #(
    parameter int COUNT_WIDTH = owbm_pkg::COUNT_WIDTH_DEF
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  owbm_pkg::cfg_t       cfg,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  owbm_pkg::item_t      in_item,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output owbm_pkg::result_t    out_result
);

    localparam int CFG_W  = owbm_pkg::CFG_W;
    localparam int WIDE_W = (COUNT_WIDTH > CFG_W) ? COUNT_WIDTH : CFG_W;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_RST_LOW = 3'd1,
        PH_RST_WT  = 3'd2,
        PH_RST_REC = 3'd3,
        PH_SLOT_LO = 3'd4,
        PH_WR_HOLD = 3'd5,
        PH_RD_WT   = 3'd6,
        PH_RD_REC  = 3'd7
    } phase_t;

    phase_t                 phase_reg, phase_next;
    owbm_pkg::cmd_t         kind_reg, kind_next;
    logic [COUNT_WIDTH-1:0] count_reg, count_next;
    logic [2:0]             bit_reg, bit_next;
    logic [7:0]             shift_reg, shift_next;
    logic                   presence_reg, presence_next;
    logic [7:0]             read_reg, read_next;
    logic                   valid_reg;
    owbm_pkg::result_t      result_reg, result_next;
    logic                   step;

    assign in_ready   = !valid_reg || out_ready;
    assign step       = in_valid && in_ready;
    assign out_valid  = valid_reg;
    assign out_result = result_reg;

    always_comb begin
        logic [CFG_W-1:0]       len_cfg;
        logic [WIDE_W-1:0]      len;
        logic [WIDE_W-1:0]      len_max;
        logic [COUNT_WIDTH-1:0] cnt1;
        logic                   at_end;
        logic                   drive, busy, done;

        phase_next    = phase_reg;
        kind_next     = kind_reg;
        count_next    = count_reg;
        bit_next      = bit_reg;
        shift_next    = shift_reg;
        presence_next = presence_reg;
        read_next     = read_reg;
        drive         = 1'b0;
        busy          = 1'b0;
        done          = 1'b0;
        len_cfg       = cfg.reset_low_ticks;
        len           = '0;
        len_max       = WIDE_W'({COUNT_WIDTH{1'b1}});
        cnt1          = '0;
        at_end        = 1'b0;

        // start a command only from idle
        if (phase_next == PH_IDLE && in_item.cmd != owbm_pkg::CMD_NONE) begin
            kind_next  = in_item.cmd;
            bit_next   = '0;
            count_next = '0;
            if (in_item.cmd == owbm_pkg::CMD_RESET) begin
                phase_next = PH_RST_LOW;
            end else begin
                shift_next = (in_item.cmd == owbm_pkg::CMD_WRITE) ? in_item.write_data : 8'h00;
                phase_next = PH_SLOT_LO;
            end
        end

        if (phase_next != PH_IDLE) begin
            busy = 1'b1;
            cnt1 = count_next + 1'b1;
            unique case (phase_next)
                PH_RST_WT:  len_cfg = cfg.presence_wait_ticks;
                PH_RST_REC: len_cfg = cfg.reset_recovery_ticks;
                PH_SLOT_LO: len_cfg = cfg.slot_low_ticks;
                PH_WR_HOLD: len_cfg = cfg.write_hold_ticks;
                PH_RD_WT:   len_cfg = cfg.read_sample_ticks;
                PH_RD_REC:  len_cfg = cfg.read_recovery_ticks;
                default:    len_cfg = cfg.reset_low_ticks;
            endcase
            // clamp to the counter range; zero acts as one
            len = WIDE_W'(len_cfg);
            if (len > len_max) begin
                len = len_max;
            end
            if (len == '0) begin
                len = WIDE_W'(1);
            end
            at_end     = (WIDE_W'(cnt1) >= len);
            count_next = at_end ? '0 : cnt1;

            unique case (phase_next)
                PH_RST_LOW: begin
                    drive = 1'b1;
                    if (at_end) phase_next = PH_RST_WT;
                end
                PH_RST_WT: begin
                    if (at_end) begin
                        presence_next = in_item.line_level;
                        phase_next    = PH_RST_REC;
                    end
                end
                PH_RST_REC: begin
                    if (at_end) begin
                        done       = 1'b1;
                        phase_next = PH_IDLE;
                    end
                end
                PH_SLOT_LO: begin
                    drive = 1'b1;
                    if (at_end) begin
                        phase_next = (kind_next == owbm_pkg::CMD_WRITE) ? PH_WR_HOLD : PH_RD_WT;
                    end
                end
                PH_WR_HOLD: begin
                    drive = !shift_next[bit_next];
                    if (at_end) begin
                        if (bit_next == 3'd7) begin
                            done       = 1'b1;
                            phase_next = PH_IDLE;
                        end else begin
                            bit_next   = bit_next + 1'b1;
                            phase_next = PH_SLOT_LO;
                        end
                    end
                end
                PH_RD_WT: begin
                    if (at_end) begin
                        if (in_item.line_level) shift_next[bit_next] = 1'b1;
                        phase_next = PH_RD_REC;
                    end
                end
                PH_RD_REC: begin
                    if (at_end) begin
                        if (bit_next == 3'd7) begin
                            read_next  = shift_next;
                            done       = 1'b1;
                            phase_next = PH_IDLE;
                        end else begin
                            bit_next   = bit_next + 1'b1;
                            phase_next = PH_SLOT_LO;
                        end
                    end
                end
                default: begin
                    phase_next = PH_IDLE;
                end
            endcase
        end

        result_next.drive_low      = drive;
        result_next.busy_res       = busy;
        result_next.done_res       = done;
        result_next.presence_level = presence_next;
        result_next.read_data      = read_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_IDLE;
            kind_reg     <= owbm_pkg::CMD_NONE;
            count_reg    <= '0;
            bit_reg      <= '0;
            shift_reg    <= '0;
            presence_reg <= 1'b1;
            read_reg     <= '0;
            valid_reg    <= 1'b0;
        end else begin
            if (in_ready) begin
                valid_reg <= in_valid;
            end
            if (step) begin
                phase_reg    <= phase_next;
                kind_reg     <= kind_next;
                count_reg    <= count_next;
                bit_reg      <= bit_next;
                shift_reg    <= shift_next;
                presence_reg <= presence_next;
                read_reg     <= read_next;
            end
        end
        if (step) begin
            result_reg <= result_next;
        end
    end

endmodule
`default_nettype wire

/* rtl/one_wire_bus_master.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// one_wire_bus_master - open-drain one-wire bus master
// Tick-driven reset/presence, byte write and byte read sequencer.
// ----------------------------------------------------------------------------
// Each request on the s_ stream is one microsecond tick carrying an optional
// command and the sampled line level; each request yields exactly one result
// on the m_ stream with the line drive, busy/done flags and the last presence
// and read values. Commands are taken only while no command runs; an opcode
// that arrives during a command is ignored. The block sustains one tick per
// clock while the consumer keeps up: an input register classifies the opcode,
// a two-entry queue decouples it from the timing engine, and the engine's
// output register holds a result while the consumer stalls. A request passes
// the input register, the queue and the engine's output register on its way
// to a result. Phase lengths come from seven 10-bit registers on the APB port
// (byte address 4*i); a value of zero acts as one, and values above the tick
// counter range (COUNT_WIDTH bits) are clamped. Write registers only while the
// block has no result outstanding.
// ----------------------------------------------------------------------------
module one_wire_bus_master #(
    parameter int COUNT_WIDTH = owbm_pkg::COUNT_WIDTH_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // tick requests
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [15:0]                   s_tdata,  // [7:0] write_data, [8] line_level
    input  wire logic [1:0]                    s_tuser,  // [1:0] opcode
    // tick results
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [15:0]                        m_tdata,  // [0] drive_low, [1] busy_res,
                                                         // [2] done_res, [3] presence_level,
                                                         // [11:4] read_data
    // configuration
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [owbm_pkg::APB_AW-1:0]   paddr,
    input  wire logic [owbm_pkg::APB_DW-1:0]   pwdata,
    output logic [owbm_pkg::APB_DW-1:0]        prdata,
    output logic                               pready
);

    localparam int CFG_W = owbm_pkg::CFG_W;

    owbm_pkg::cfg_t    cfg_reg;
    owbm_pkg::item_t   front_item, queue_item;
    owbm_pkg::result_t result;
    logic              front_valid, front_ready;
    logic              queue_valid, queue_ready;
    logic              cfg_write;
    logic [2:0]        reg_sel;
    logic [CFG_W-1:0]  rd_value;

    // ---------------- configuration registers ----------------
    assign pready    = 1'b1;
    assign reg_sel   = paddr[4:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.reset_low_ticks      <= owbm_pkg::RST_RESET_LOW;
            cfg_reg.presence_wait_ticks  <= owbm_pkg::RST_PRESENCE_WAIT;
            cfg_reg.reset_recovery_ticks <= owbm_pkg::RST_RESET_REC;
            cfg_reg.slot_low_ticks       <= owbm_pkg::RST_SLOT_LOW;
            cfg_reg.write_hold_ticks     <= owbm_pkg::RST_WRITE_HOLD;
            cfg_reg.read_sample_ticks    <= owbm_pkg::RST_READ_SAMPLE;
            cfg_reg.read_recovery_ticks  <= owbm_pkg::RST_READ_REC;
        end else if (cfg_write) begin
            unique case (reg_sel)
                owbm_pkg::REG_RESET_LOW:     cfg_reg.reset_low_ticks      <= pwdata[CFG_W-1:0];
                owbm_pkg::REG_PRESENCE_WAIT: cfg_reg.presence_wait_ticks  <= pwdata[CFG_W-1:0];
                owbm_pkg::REG_RESET_REC:     cfg_reg.reset_recovery_ticks <= pwdata[CFG_W-1:0];
                owbm_pkg::REG_SLOT_LOW:      cfg_reg.slot_low_ticks       <= pwdata[CFG_W-1:0];
                owbm_pkg::REG_WRITE_HOLD:    cfg_reg.write_hold_ticks     <= pwdata[CFG_W-1:0];
                owbm_pkg::REG_READ_SAMPLE:   cfg_reg.read_sample_ticks    <= pwdata[CFG_W-1:0];
                owbm_pkg::REG_READ_REC:      cfg_reg.read_recovery_ticks  <= pwdata[CFG_W-1:0];
                default: ;  // drop writes past the register map
            endcase
        end
    end

    // read back; unmapped addresses return zero
    always_comb begin
        unique case (reg_sel)
            owbm_pkg::REG_RESET_LOW:     rd_value = cfg_reg.reset_low_ticks;
            owbm_pkg::REG_PRESENCE_WAIT: rd_value = cfg_reg.presence_wait_ticks;
            owbm_pkg::REG_RESET_REC:     rd_value = cfg_reg.reset_recovery_ticks;
            owbm_pkg::REG_SLOT_LOW:      rd_value = cfg_reg.slot_low_ticks;
            owbm_pkg::REG_WRITE_HOLD:    rd_value = cfg_reg.write_hold_ticks;
            owbm_pkg::REG_READ_SAMPLE:   rd_value = cfg_reg.read_sample_ticks;
            owbm_pkg::REG_READ_REC:      rd_value = cfg_reg.read_recovery_ticks;
            default:                     rd_value = '0;
        endcase
    end
    assign prdata = owbm_pkg::APB_DW'(rd_value);

    // ---------------- input stage: register and classify ----------------
    owbm_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_valid      (s_tvalid),
        .in_ready      (s_tready),
        .in_opcode     (s_tuser),
        .in_write_data (s_tdata[7:0]),
        .in_line_level (s_tdata[8]),
        .out_valid     (front_valid),
        .out_ready     (front_ready),
        .out_item      (front_item)
    );

    // ---------------- queue: decouple front from engine ----------------
    owbm_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .push_item  (front_item),
        .pop_valid  (queue_valid),
        .pop_ready  (queue_ready),
        .pop_item   (queue_item)
    );

    // ---------------- engine: advance the bus sequence ----------------
    owbm_engine #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_engine (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .in_valid   (queue_valid),
        .in_ready   (queue_ready),
        .in_item    (queue_item),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_result (result)
    );

    // pack the result, drive_low in the lowest bit, zero-fill the top nibble
    assign m_tdata = {4'h0, result.read_data, result.presence_level,
                      result.done_res, result.busy_res, result.drive_low};

endmodule
`default_nettype wire
